>>> src/sws_pkg.sv
// ----------------------------------------------------------------------------
// sws_pkg
// Shared constants and types for the sliding window statistics block.
// ----------------------------------------------------------------------------
package sws_pkg;

  localparam int unsigned DEPTH       = 16;
  localparam int unsigned IDX_W       = $clog2(DEPTH);
  localparam int unsigned LEN_W       = IDX_W + 1;
  localparam int unsigned CFG_W       = 5;
  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned SUM_W       = SAMPLE_W + IDX_W + 1;
  localparam int unsigned MAG_W       = SUM_W - 1;
  localparam int unsigned DIV_CNT_W   = $clog2(MAG_W);
  localparam int unsigned STEP_W      = 4;
  localparam int unsigned OUT_W       = 5 * SAMPLE_W + 2 * STEP_W;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = QPTR_W + 1;

  localparam logic [CFG_W-1:0]  LEN_RESET = CFG_W'(DEPTH);
  localparam logic [STEP_W-1:0] STEP_MAX  = '1;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;

  typedef enum logic {
    JOB_PUSH,
    JOB_PRIME
  } job_kind_e;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    job_kind_e                  kind;
    logic [LEN_W-1:0]           len;
  } job_t;

endpackage

>>> src/sws_queue.sv
// ----------------------------------------------------------------------------
// sws_queue
// Short job queue between the front and the back of the block.
// ----------------------------------------------------------------------------
module sws_queue
  import sws_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  job_t  push_job_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output job_t  pop_job_o
);

  job_t              slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q;
  logic [QPTR_W-1:0] rd_ptr_q;
  logic [QCNT_W-1:0] count_q;

  assign full_o    = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o   = (count_q != '0);
  assign pop_job_o = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + QCNT_W'(1);
      end else if (!push_i && pop_i) begin
        count_q <= count_q - QCNT_W'(1);
      end
    end
  end

endmodule

>>> src/sws_front.sv
// ----------------------------------------------------------------------------
// sws_front
// Input side: holds the window length register, classifies each item and
// tags it with the effective window length before it enters the queue.
// ----------------------------------------------------------------------------
module sws_front
  import sws_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CFG_W-1:0]    cfg_wdata_i,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [SAMPLE_W-1:0] s_axis_tdata_i,
  input  logic                s_axis_tuser_i,
  input  logic                queue_full_i,
  output logic                push_o,
  output job_t                job_o
);

  logic [CFG_W-1:0] win_len_q;
  logic [LEN_W-1:0] eff_len;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_len_q <= LEN_RESET;
    end else if (cfg_we_i) begin
      win_len_q <= cfg_wdata_i;
    end
  end

  // A length of zero acts as one; anything beyond the depth is clamped.
  always_comb begin
    if (win_len_q == '0) begin
      eff_len = LEN_W'(1);
    end else if (win_len_q > CFG_W'(DEPTH)) begin
      eff_len = LEN_W'(DEPTH);
    end else begin
      eff_len = LEN_W'(win_len_q);
    end
  end

  assign s_axis_tready_o = !queue_full_i;
  assign push_o          = s_axis_tvalid_i && !queue_full_i;

  always_comb begin
    job_o.sample = $signed(s_axis_tdata_i);
    job_o.kind   = s_axis_tuser_i ? JOB_PRIME : JOB_PUSH;
    job_o.len    = eff_len;
  end

endmodule

>>> src/sws_back.sv
// ----------------------------------------------------------------------------
// sws_back
// Execution side: updates the sample window, walks it one entry per cycle,
// divides the sum serially and drives the registered result item.
// ----------------------------------------------------------------------------
module sws_back
  import sws_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             job_valid_i,
  input  job_t             job_i,
  output logic             pop_o,
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  output logic [OUT_W-1:0] m_axis_tdata_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_PREP,
    ST_DIV,
    ST_MEAN,
    ST_EMIT
  } state_e;

  state_e                     state_q;
  logic signed [SAMPLE_W-1:0] win_q [DEPTH];
  logic [LEN_W-1:0]           len_q;
  logic [IDX_W-1:0]           idx_q;
  logic signed [SAMPLE_W-1:0] prev_q;
  logic signed [SAMPLE_W-1:0] max_q;
  logic signed [SAMPLE_W-1:0] min_q;
  logic signed [SUM_W-1:0]    sum_q;
  logic [STEP_W-1:0]          rise_q;
  logic [STEP_W-1:0]          fall_q;
  logic [MAG_W-1:0]           dvd_q;
  logic [MAG_W-1:0]           quo_q;
  logic [LEN_W-1:0]           rem_q;
  logic                       neg_q;
  logic [DIV_CNT_W-1:0]       cnt_q;
  logic signed [SAMPLE_W-1:0] mean_q;
  logic                       out_valid_q;
  logic [OUT_W-1:0]           out_data_q;

  logic signed [SAMPLE_W-1:0] cur;
  logic                       last;
  logic [LEN_W-1:0]           rem_sh;
  logic                       rem_ge;
  logic signed [SUM_W-1:0]    sum_abs;
  logic signed [SUM_W-1:0]    quo_ext;
  logic signed [SUM_W-1:0]    mean_full;
  logic signed [SAMPLE_W+1:0] diff;
  logic signed [SAMPLE_W+2:0] trend_full;
  logic signed [SAMPLE_W-1:0] trend;
  logic [SAMPLE_W-1:0]        spread;

  assign pop_o = (state_q == ST_IDLE) && job_valid_i;
  assign cur   = win_q[idx_q];
  assign last  = (LEN_W'(idx_q) == len_q - LEN_W'(1));

  // One restoring division step: the remainder stays below the length.
  assign rem_sh = {rem_q[IDX_W-1:0], dvd_q[MAG_W-1]};
  assign rem_ge = (rem_sh >= len_q);

  assign sum_abs   = sum_q[SUM_W-1] ? -sum_q : sum_q;
  assign quo_ext   = $signed({1'b0, quo_q});
  assign mean_full = neg_q ? -quo_ext : quo_ext;

  assign diff       = $signed({{2{win_q[0][SAMPLE_W-1]}}, win_q[0]})
                    - $signed({{2{mean_q[SAMPLE_W-1]}}, mean_q});
  assign trend_full = $signed({diff, 1'b0});

  always_comb begin
    if (trend_full < $signed({{3{SAMPLE_MIN[SAMPLE_W-1]}}, SAMPLE_MIN})) begin
      trend = SAMPLE_MIN;
    end else if (trend_full > $signed({3'b000, SAMPLE_MAX})) begin
      trend = SAMPLE_MAX;
    end else begin
      trend = trend_full[SAMPLE_W-1:0];
    end
  end

  assign spread = SAMPLE_W'(max_q - min_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      for (int i = 0; i < DEPTH; i++) begin
        win_q[i] <= '0;
      end
      len_q       <= LEN_W'(DEPTH);
      idx_q       <= '0;
      prev_q      <= '0;
      max_q       <= SAMPLE_MIN;
      min_q       <= SAMPLE_MAX;
      sum_q       <= '0;
      rise_q      <= '0;
      fall_q      <= '0;
      dvd_q       <= '0;
      quo_q       <= '0;
      rem_q       <= '0;
      neg_q       <= 1'b0;
      cnt_q       <= '0;
      mean_q      <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      // In the emit state the result register is refilled instead.
      if (m_axis_tready_i && (state_q != ST_EMIT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (job_valid_i) begin
            for (int i = 1; i < DEPTH; i++) begin
              win_q[i] <= (job_i.kind == JOB_PRIME) ? job_i.sample : win_q[i-1];
            end
            win_q[0] <= job_i.sample;
            len_q    <= job_i.len;
            idx_q    <= '0;
            max_q    <= SAMPLE_MIN;
            min_q    <= SAMPLE_MAX;
            sum_q    <= '0;
            rise_q   <= '0;
            fall_q   <= '0;
            state_q  <= ST_WALK;
          end
        end
        ST_WALK: begin
          if (cur > max_q) begin
            max_q <= cur;
          end
          if (cur < min_q) begin
            min_q <= cur;
          end
          sum_q <= sum_q + $signed({{(SUM_W-SAMPLE_W){cur[SAMPLE_W-1]}}, cur});
          if (idx_q != '0) begin
            if ((prev_q > cur) && (rise_q != STEP_MAX)) begin
              rise_q <= rise_q + STEP_W'(1);
            end
            if ((prev_q < cur) && (fall_q != STEP_MAX)) begin
              fall_q <= fall_q + STEP_W'(1);
            end
          end
          prev_q <= cur;
          idx_q  <= idx_q + IDX_W'(1);
          if (last) begin
            state_q <= ST_PREP;
          end
        end
        ST_PREP: begin
          dvd_q   <= sum_abs[MAG_W-1:0];
          neg_q   <= sum_q[SUM_W-1];
          rem_q   <= '0;
          quo_q   <= '0;
          cnt_q   <= '0;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          rem_q <= rem_ge ? (rem_sh - len_q) : rem_sh;
          quo_q <= {quo_q[MAG_W-2:0], rem_ge};
          dvd_q <= {dvd_q[MAG_W-2:0], 1'b0};
          cnt_q <= cnt_q + DIV_CNT_W'(1);
          if (cnt_q == DIV_CNT_W'(MAG_W - 1)) begin
            state_q <= ST_MEAN;
          end
        end
        ST_MEAN: begin
          mean_q  <= mean_full[SAMPLE_W-1:0];
          state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          if (!out_valid_q || m_axis_tready_i) begin
            out_valid_q <= 1'b1;
            out_data_q  <= {fall_q, rise_q, trend, mean_q, spread, min_q, max_q};
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

>>> src/sliding_window_statistics.sv
// ----------------------------------------------------------------------------
// sliding_window_statistics
// Max, min, spread, mean, trend and step counts over a window of samples.
// ----------------------------------------------------------------------------
// Usage: each input item carries one signed 16-bit sample in tdata and the
// prime flag in tuser; a set prime flag fills the whole window with the
// sample. Every accepted item yields exactly one result item on the output
// stream, in order. The user must write the window length register through
// cfg_we_i/cfg_wdata_i only while the block is idle; the block itself does not
// enforce this. Zero acts as one and values above sixteen act as sixteen.
// Execution: each item passes through the walk, prep, divide, mean and emit
// states in turn; the execution side takes the next item only once it is back
// in idle. The cost is set by the one-entry-per-cycle walk over the window
// and the one-bit-per-cycle serial divider that forms the mean.
// A two-entry queue sits between the input side and the execution side, so
// new items are taken while a result waits in the output register; the input
// stalls only when that queue is full. A stalled receiver holds the result
// steady and, once the next result is ready, stops the execution side.
// Reset clears the window to zero, sets the length to sixteen and drops all
// queued items and any pending result.
// ----------------------------------------------------------------------------
module sliding_window_statistics
  import sws_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CFG_W-1:0]    cfg_wdata_i,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // sample [15:0]
  input  logic [SAMPLE_W-1:0] s_axis_tdata_i,
  // prime [0]
  input  logic                s_axis_tuser_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // window_max [15:0], window_min [31:16], spread [47:32], mean [63:48],
  // trend [79:64], rising_steps [83:80], falling_steps [87:84]
  output logic [OUT_W-1:0]    m_axis_tdata_o
);

  logic queue_full;
  logic push;
  job_t push_job;
  logic pop;
  logic job_valid;
  job_t pop_job;

  sws_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .queue_full_i    (queue_full),
    .push_o          (push),
    .job_o           (push_job)
  );

  sws_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .full_o     (queue_full),
    .pop_i      (pop),
    .valid_o    (job_valid),
    .pop_job_o  (pop_job)
  );

  sws_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .job_valid_i     (job_valid),
    .job_i           (pop_job),
    .pop_o           (pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

endmodule
